// ===== rtl/core/stag_pkg.sv =====
// shared constants, types and lane helpers for the strided tile address generator
package stag_pkg;

  localparam int unsigned MAX_DIMS     = 4;
  localparam int unsigned EXTENT_BITS  = 16;
  localparam int unsigned ADDR_BITS    = 32;
  localparam int unsigned CFG_BITS     = 64;
  localparam int unsigned RANK_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic [EXTENT_BITS-1:0] ext_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [CFG_BITS-1:0]    cfg_word_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OUT_RANK    = 3'd0,
    CFG_OUT_EXTENTS = 3'd1,
    CFG_SRC_EXTENTS = 3'd2,
    CFG_SRC_STRIDES = 3'd3,
    CFG_DST_STRIDES = 3'd4,
    CFG_SRC_BASE    = 3'd5,
    CFG_DST_BASE    = 3'd6
  } cfg_reg_e;

  // indices of one element, handed from the odometer to the address datapath
  typedef struct packed {
    ext_t [MAX_DIMS-1:0] out_idx;
    ext_t [MAX_DIMS-1:0] src_idx;
    logic                last;
  } walk_t;

  // lanes that lie beyond the packed word read as zero
  function automatic ext_t lane(cfg_word_t r, int unsigned d);
    if (d * EXTENT_BITS >= CFG_BITS) begin
      return '0;
    end
    return r[d*EXTENT_BITS +: EXTENT_BITS];
  endfunction

  // last valid index of an extent, a zero extent acting as one
  function automatic ext_t end_of(ext_t e);
    return (e == '0) ? '0 : e - ext_t'(1);
  endfunction

  // index widened to the address width, unsigned
  function automatic addr_t zext(ext_t v);
    return {{(ADDR_BITS-EXTENT_BITS){1'b0}}, v};
  endfunction

  // stride widened to the address width, two's complement
  function automatic addr_t sext(ext_t v);
    return {{(ADDR_BITS-EXTENT_BITS){v[EXTENT_BITS-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/stag_odometer.sv =====
// output and source index odometer, advanced once per accepted beat
module stag_odometer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              restart_i,
  input  logic [stag_pkg::RANK_BITS-1:0]    out_rank_i,
  input  stag_pkg::cfg_word_t               out_extents_i,
  input  stag_pkg::cfg_word_t               src_extents_i,
  output stag_pkg::walk_t                   walk_o
);

  stag_pkg::ext_t [stag_pkg::MAX_DIMS-1:0] out_idx_q, out_idx_d;
  stag_pkg::ext_t [stag_pkg::MAX_DIMS-1:0] src_idx_q, src_idx_d;
  stag_pkg::ext_t [stag_pkg::MAX_DIMS-1:0] cur_out, cur_src;
  logic [stag_pkg::MAX_DIMS-1:0] used, at_end, src_at_end, carry;

  always_comb begin
    for (int unsigned d = 0; d < stag_pkg::MAX_DIMS; d++) begin
      used[d]       = 32'(out_rank_i) > d;
      cur_out[d]    = restart_i ? '0 : out_idx_q[d];
      cur_src[d]    = restart_i ? '0 : src_idx_q[d];
      at_end[d]     = cur_out[d] >=
                      stag_pkg::end_of(stag_pkg::lane(out_extents_i, d));
      src_at_end[d] = cur_src[d] >=
                      stag_pkg::end_of(stag_pkg::lane(src_extents_i, d));
    end

    // innermost used dimension always steps, outer ones only on a full carry
    carry[stag_pkg::MAX_DIMS-1] = 1'b1;
    for (int d = int'(stag_pkg::MAX_DIMS) - 2; d >= 0; d--) begin
      carry[d] = carry[d+1] && (!used[d+1] || at_end[d+1]);
    end

    for (int unsigned d = 0; d < stag_pkg::MAX_DIMS; d++) begin
      out_idx_d[d] = cur_out[d];
      src_idx_d[d] = cur_src[d];
      if (used[d] && carry[d]) begin
        if (at_end[d]) begin
          out_idx_d[d] = '0;
          src_idx_d[d] = '0;
        end else begin
          out_idx_d[d] = cur_out[d] + stag_pkg::ext_t'(1);
          src_idx_d[d] = src_at_end[d] ? '0 : cur_src[d] + stag_pkg::ext_t'(1);
        end
      end
      walk_o.out_idx[d] = used[d] ? cur_out[d] : '0;
      walk_o.src_idx[d] = used[d] ? cur_src[d] : '0;
    end
    walk_o.last = &(~used | at_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_idx_q <= '0;
      src_idx_q <= '0;
    end else if (step_i) begin
      out_idx_q <= out_idx_d;
      src_idx_q <= src_idx_d;
    end
  end

endmodule

// ===== rtl/core/strided_tile_address_generator_top.sv =====
// top level: config registers, index odometer and the three-stage address pipeline
//
// Walks an N-dimensional tile in row-major order and returns one source and one
// destination address per input beat. A new beat is taken every cycle unless the
// pipeline is full behind a stalled output; each beat passes the walk register, the
// stride product register and the result register (base plus sum), and the
// pipeline holds up to three beats while the output is stalled.
// Throughput is set by the odometer update, which is done in the accept cycle.
// Configuration writes are taken in any cycle but must only be issued while the
// block is empty.
module strided_tile_address_generator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [stag_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [stag_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [stag_pkg::ADDR_BITS-1:0]       src_address_o,
  output logic [stag_pkg::ADDR_BITS-1:0]       dst_address_o,
  output logic                                 last_element_o
);

  logic [stag_pkg::RANK_BITS-1:0] out_rank_q;
  stag_pkg::cfg_word_t out_extents_q, src_extents_q, src_strides_q, dst_strides_q;
  stag_pkg::addr_t     src_base_q, dst_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rank_q    <= stag_pkg::RANK_BITS'(1);
      out_extents_q <= stag_pkg::CFG_BITS'(1);
      src_extents_q <= stag_pkg::CFG_BITS'(1);
      src_strides_q <= '0;
      dst_strides_q <= '0;
      src_base_q    <= '0;
      dst_base_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stag_pkg::CFG_OUT_RANK:    out_rank_q    <= cfg_data_i[stag_pkg::RANK_BITS-1:0];
        stag_pkg::CFG_OUT_EXTENTS: out_extents_q <= cfg_data_i;
        stag_pkg::CFG_SRC_EXTENTS: src_extents_q <= cfg_data_i;
        stag_pkg::CFG_SRC_STRIDES: src_strides_q <= cfg_data_i;
        stag_pkg::CFG_DST_STRIDES: dst_strides_q <= cfg_data_i;
        stag_pkg::CFG_SRC_BASE:    src_base_q    <= cfg_data_i[stag_pkg::ADDR_BITS-1:0];
        stag_pkg::CFG_DST_BASE:    dst_base_q    <= cfg_data_i[stag_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // per-stage ready, each stage moves when the one after it has room
  logic a_valid_q, b_valid_q, o_valid_q;
  logic ready_a, ready_b, ready_o;
  logic in_fire;

  assign ready_o    = !o_valid_q || out_ready_i;
  assign ready_b    = !b_valid_q || ready_o;
  assign ready_a    = !a_valid_q || ready_b;
  assign in_ready_o = ready_a;
  assign in_fire    = in_valid_i && ready_a;

  stag_pkg::walk_t walk;

  stag_odometer u_odometer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .restart_i     (restart_i),
    .out_rank_i    (out_rank_q),
    .out_extents_i (out_extents_q),
    .src_extents_i (src_extents_q),
    .walk_o        (walk)
  );

  stag_pkg::walk_t a_walk_q;
  stag_pkg::addr_t [stag_pkg::MAX_DIMS-1:0] src_prod_d, dst_prod_d;
  stag_pkg::addr_t [stag_pkg::MAX_DIMS-1:0] b_src_prod_q, b_dst_prod_q;
  logic            b_last_q;
  stag_pkg::addr_t src_sum, dst_sum;
  stag_pkg::addr_t o_src_q, o_dst_q;
  logic            o_last_q;

  // index is unsigned, stride is two's complement; product wraps to the address width
  always_comb begin
    for (int unsigned d = 0; d < stag_pkg::MAX_DIMS; d++) begin
      src_prod_d[d] = stag_pkg::zext(a_walk_q.src_idx[d]) *
                      stag_pkg::sext(stag_pkg::lane(src_strides_q, d));
      dst_prod_d[d] = stag_pkg::zext(a_walk_q.out_idx[d]) *
                      stag_pkg::sext(stag_pkg::lane(dst_strides_q, d));
    end
  end

  always_comb begin
    src_sum = src_base_q;
    dst_sum = dst_base_q;
    for (int unsigned d = 0; d < stag_pkg::MAX_DIMS; d++) begin
      src_sum = src_sum + b_src_prod_q[d];
      dst_sum = dst_sum + b_dst_prod_q[d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (ready_a) a_valid_q <= in_valid_i;
      if (ready_b) b_valid_q <= a_valid_q;
      if (ready_o) o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_walk_q <= walk;
    end
    if (ready_b && a_valid_q) begin
      b_src_prod_q <= src_prod_d;
      b_dst_prod_q <= dst_prod_d;
      b_last_q     <= a_walk_q.last;
    end
    if (ready_o && b_valid_q) begin
      o_src_q  <= src_sum;
      o_dst_q  <= dst_sum;
      o_last_q <= b_last_q;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign src_address_o  = o_src_q;
  assign dst_address_o  = o_dst_q;
  assign last_element_o = o_last_q;

endmodule

// ===== rtl/core/stag_checker.sv =====
// port-level checker for the strided tile address generator, bound to the top level
module stag_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [stag_pkg::ADDR_BITS-1:0]  src_address_o,
  input logic [stag_pkg::ADDR_BITS-1:0]  dst_address_o,
  input logic                            last_element_o
);

  // beats accepted but not yet delivered
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && in_ready_o)   cnt_d = cnt_d + 3'd1;
    if (out_valid_o && out_ready_i) cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // no result without a beat in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result shown with no beat in flight");

  // three pipeline stages bound the occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more beats in flight than pipeline stages");

  // input only stalls when the whole pipeline backs up behind the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(src_address_o) &&
      $stable(dst_address_o) && $stable(last_element_o))
    else $error("stalled result changed");

endmodule

bind strided_tile_address_generator_top stag_checker u_checker (.*);
